// ===== rtl/hns_pkg.sv =====
// Shared types, constants and helper functions of the nonce search block.
// No dependencies.
package hns_pkg;

    localparam int SHARE_DEPTH = 256;
    localparam int PTR_W       = $clog2(SHARE_DEPTH);
    localparam int HDR_WORDS   = 19;
    localparam int HDR_IDX_W   = $clog2(HDR_WORDS);

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_TEST    = 2'd1;
    localparam logic [1:0] OP_POP     = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    localparam logic [2:0] ST_NO_SHARE  = 3'd0;
    localparam logic [2:0] ST_SHARE     = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_POPPED    = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_ACK       = 3'd5;

    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_START  = 2'd1;
    localparam logic [1:0] CFG_END    = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  word_index;
        logic [31:0] word_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] nonce_value;
        logic [31:0] hash_top;
    } t_out_item;

    typedef struct packed {
        logic [1:0]           opcode;
        logic                 idx_ok;
        logic [HDR_IDX_W-1:0] hdr_idx;
        logic [31:0]          data;
    } t_cmd;

    typedef logic [7:0][31:0] t_state;

    typedef struct packed {
        logic       done;
        logic [5:0] round;
    } t_sha_stat;

    localparam t_state SHA_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // key byte b is b itself, xored with the pad byte
    function automatic logic [31:0] pad_word(input logic [3:0] j, input logic [7:0] pad);
        return {{2'b00, j, 2'd0} ^ pad, {2'b00, j, 2'd1} ^ pad,
                {2'b00, j, 2'd2} ^ pad, {2'b00, j, 2'd3} ^ pad};
    endfunction

    function automatic logic [31:0] sha_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/hns_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/hns_front.sv =====
// Front end: two-entry command queue that accepts and classifies items.
// Depends on hns_pkg.
module hns_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  hns_pkg::t_in_item i_item,
    input  logic            i_take,
    output logic            o_empty,
    output hns_pkg::t_cmd   o_cmd
);
    import hns_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       do_push, do_take;

    always_comb begin
        cls.opcode  = i_item.opcode;
        cls.idx_ok  = i_item.word_index < 5'(HDR_WORDS);
        cls.hdr_idx = HDR_IDX_W'(i_item.word_index);
        cls.data    = i_item.word_data;
    end

    assign full    = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = push && !full;
    assign do_take = i_take && !o_empty;
    assign o_cmd   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= cls;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= !r_wr;
            if (do_take) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_take};
        end
    end
endmodule

// ===== rtl/hns_sha.sv =====
// SHA-256 compression unit, one round per cycle, message words fed in for rounds 0..15.
// Depends on hns_pkg.
module hns_sha (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  hns_pkg::t_state    i_chain,
    input  logic [31:0]        i_word,
    output hns_pkg::t_sha_stat o_stat,
    output hns_pkg::t_state    o_digest
);
    import hns_pkg::*;

    t_state      r_v, r_h;
    logic [31:0] r_w [16];
    logic [5:0]  r_round;
    logic        r_busy, r_fin, r_done;
    logic [31:0] w_t, s0, s1, t1, t2, big_s0, big_s1, ch, maj;

    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_t = (r_round[5:4] == 2'd0) ? i_word : r_w[0] + s0 + r_w[9] + s1;
        big_s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1     = r_v[7] + big_s1 + ch + sha_k(r_round) + w_t;
        big_s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2     = big_s0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_chain;
            r_h <= i_chain;
        end else if (r_busy) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_t;
        end else if (r_fin) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_done  <= 1'b0;
            r_round <= 6'd0;
        end else begin
            r_done <= r_fin;
            r_fin  <= !i_start && r_busy && (r_round == 6'd63);
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 6'd0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.round = r_round;
    assign o_digest     = r_h;
endmodule

// ===== rtl/hns_back.sv =====
// Back end: command sequencer, header store, share ring, config registers, result register.
// Depends on hns_pkg, hns_sha, hns_ram.
module hns_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  hns_pkg::t_cmd      i_cmd,
    output logic               o_take,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic               empty,
    input  logic               pop,
    output hns_pkg::t_out_item o_out_item
);
    import hns_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_HASH  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    localparam logic [2:0] BLK_IPAD  = 3'd0;
    localparam logic [2:0] BLK_MSG0  = 3'd1;
    localparam logic [2:0] BLK_MSG1  = 3'd2;
    localparam logic [2:0] BLK_OPAD  = 3'd3;
    localparam logic [2:0] BLK_OUTER = 3'd4;

    logic [1:0]       r_state;
    logic [2:0]       r_blk;
    logic             r_sha_start;
    logic [31:0]      r_target, r_start_nonce, r_end_nonce, r_nonce, r_top;
    logic [31:0]      r_hdr [HDR_WORDS];
    t_state           r_inner;
    logic [PTR_W-1:0] r_wp, r_rp;
    logic             r_out_valid;
    t_out_item        r_out;

    t_sha_stat        sha_stat;
    t_state           sha_digest, sha_chain;
    logic [31:0]      word, ring_rdata;
    logic [3:0]       j;
    logic             is_share, ring_we, ring_re;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(SHARE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign j = sha_stat.round[3:0];

    always_comb begin
        word = 32'h0;
        case (r_blk)
            BLK_IPAD: word = pad_word(j, 8'h36);
            BLK_MSG0: word = bswap32(r_hdr[HDR_IDX_W'(j)]);
            BLK_MSG1: begin
                if (j < 4'd3)       word = bswap32(r_hdr[HDR_IDX_W'(16) + HDR_IDX_W'(j)]);
                else if (j == 4'd3) word = bswap32(r_nonce);
                else if (j == 4'd4) word = 32'h8000_0000;
                else if (j == 4'd15) word = 32'd1152;
            end
            BLK_OPAD: word = pad_word(j, 8'h5c);
            BLK_OUTER: begin
                if (j < 4'd8)        word = r_inner[j[2:0]];
                else if (j == 4'd8)  word = 32'h8000_0000;
                else if (j == 4'd15) word = 32'd768;
            end
            default: word = 32'h0;
        endcase
        sha_chain = (r_blk == BLK_IPAD || r_blk == BLK_OPAD) ? SHA_IV : sha_digest;
    end

    hns_sha u_sha (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_sha_start),
        .i_chain  (sha_chain),
        .i_word   (word),
        .o_stat   (sha_stat),
        .o_digest (sha_digest)
    );

    assign is_share = (r_top[31:24] == 8'h0) && (r_top <= r_target);
    assign o_take   = (r_state == S_IDLE) && !i_q_empty && !r_out_valid;
    assign ring_we  = (r_state == S_CHECK) && is_share;
    assign ring_re  = o_take && (i_cmd.opcode == OP_POP);

    hns_ram #(.WIDTH(32), .DEPTH(SHARE_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (r_nonce),
        .i_re    (ring_re),
        .i_raddr (r_rp),
        .o_rdata (ring_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (o_take && i_cmd.opcode == OP_LOAD && i_cmd.idx_ok) begin
            r_hdr[i_cmd.hdr_idx] <= i_cmd.data;
        end
        if (r_state == S_HASH && sha_stat.done) begin
            if (r_blk == BLK_MSG1) r_inner <= sha_digest;
            if (r_blk == BLK_OUTER) r_top <= bswap32(sha_digest[7]);
        end
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_blk         <= BLK_IPAD;
            r_sha_start   <= 1'b0;
            r_target      <= 32'h0;
            r_start_nonce <= 32'h0;
            r_end_nonce   <= 32'hffff_ffff;
            r_nonce       <= 32'h0;
            r_wp          <= '0;
            r_rp          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_sha_start <= (o_take && i_cmd.opcode == OP_TEST && r_nonce < r_end_nonce)
                        || (r_state == S_HASH && sha_stat.done && r_blk != BLK_OUTER);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET: r_target      <= i_cfg_data;
                    CFG_START:  r_start_nonce <= i_cfg_data;
                    CFG_END:    r_end_nonce   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (pop && r_out_valid) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        case (i_cmd.opcode)
                            OP_LOAD: begin
                                r_out <= '{status: ST_ACK, nonce_value: 32'h0,
                                           hash_top: 32'h0};
                                r_wp <= '0;
                                r_rp <= '0;
                                r_out_valid <= 1'b1;
                            end
                            OP_TEST: begin
                                if (r_nonce >= r_end_nonce) begin
                                    r_out <= '{status: ST_EXHAUSTED, nonce_value: r_nonce,
                                               hash_top: 32'h0};
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_blk   <= BLK_IPAD;
                                    r_state <= S_HASH;
                                end
                            end
                            OP_POP: begin
                                if (r_wp == r_rp) begin
                                    r_out <= '{status: ST_EMPTY, nonce_value: 32'h0,
                                               hash_top: 32'h0};
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_state <= S_POP;
                                end
                            end
                            OP_RESTART: begin
                                r_out <= '{status: ST_ACK, nonce_value: 32'h0,
                                           hash_top: 32'h0};
                                r_nonce <= r_start_nonce;
                                r_wp <= '0;
                                r_rp <= '0;
                                r_out_valid <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_POP: begin
                    r_out <= '{status: ST_POPPED, nonce_value: ring_rdata, hash_top: 32'h0};
                    r_rp        <= ptr_inc(r_rp);
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_HASH: begin
                    if (sha_stat.done) begin
                        if (r_blk == BLK_OUTER) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_blk <= r_blk + 3'd1;
                        end
                    end
                end
                S_CHECK: begin
                    r_out.status      <= is_share ? ST_SHARE : ST_NO_SHARE;
                    r_out.nonce_value <= r_nonce;
                    r_out.hash_top    <= r_top;
                    if (is_share) r_wp <= ptr_inc(r_wp);
                    r_nonce     <= r_nonce + 32'd1;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign empty      = !r_out_valid;
    assign o_out_item = r_out;
endmodule

// ===== rtl/hmac_nonce_search_share_buffer_core.sv =====
// Nonce search engine with HMAC-SHA256 and a share ring: top level.
// Depends on hns_pkg, hns_front, hns_back.
//
// Items enter through a two-entry command queue and are executed one at a time.
// Header loads, restarts, empty pops and exhausted tests are answered from the idle
// state, a pop that returns a share after an extra ring read state. A test runs five
// SHA-256 compressions on the single one-round-per-cycle compression unit.
// A result waits in the output register until popped; no item is executed meanwhile,
// though the queue keeps accepting items until it is full.
module hmac_nonce_search_share_buffer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  hns_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output hns_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import hns_pkg::*;

    t_cmd cmd;
    logic q_empty, take;

    hns_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_in_item),
        .i_take  (take),
        .o_empty (q_empty),
        .o_cmd   (cmd)
    );

    hns_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_cmd      (cmd),
        .o_take     (take),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );
endmodule
